>>> rtl/core/quadrature_pid_wheel_sync_assert.svh
// Assertion helpers shared by the wheel sync RTL.
// Both sample on the rising clock and stay quiet while reset is high.
`ifndef QUADRATURE_PID_WHEEL_SYNC_ASSERT_SVH
`define QUADRATURE_PID_WHEEL_SYNC_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QPWS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qpws: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define QPWS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qpws: next-cycle check failed");

`endif

>>> rtl/core/qpws_pkg.sv
package qpws_pkg;

   localparam int COUNT_BITS     = 32;
   localparam int GAIN_FRAC_BITS = 12;
   localparam int GAIN_BITS      = 16;
   localparam int DUTY_BITS      = 10;
   localparam int POS_BITS       = 32;
   localparam int ERR_BITS       = 32;
   localparam int DIFF_BITS      = ERR_BITS + 1;
   localparam int PROD_BITS      = GAIN_BITS + 1 + DIFF_BITS;
   localparam int PID_BITS       = PROD_BITS + 2;
   localparam int CORR_FULL_BITS = PID_BITS - GAIN_FRAC_BITS;
   // Any correction beyond this range already pins both duties to a clamp bound.
   localparam int CORR_BITS      = DUTY_BITS + 2;
   localparam int CALC_BITS      = DUTY_BITS + 4;
   localparam int CSR_INDEX_BITS = 3;

   localparam int REQ_FIELD_BITS = 2 + 2 + 1 + DUTY_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * DUTY_BITS + 2 + 1 + 2 * POS_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic signed [CORR_BITS-1:0] CORR_HI = {1'b0, {(CORR_BITS-1){1'b1}}};
   localparam logic signed [CORR_BITS-1:0] CORR_LO = {1'b1, {(CORR_BITS-1){1'b0}}};

   localparam logic [GAIN_BITS-1:0] GAIN_P_RESET     = 16'd4915;
   localparam logic [GAIN_BITS-1:0] GAIN_I_RESET     = 16'd33;
   localparam logic [GAIN_BITS-1:0] GAIN_D_RESET     = 16'd0;
   localparam logic [DUTY_BITS-1:0] LEFT_TRIM_RESET  = 10'd200;
   localparam logic [DUTY_BITS-1:0] RIGHT_TRIM_RESET = 10'd0;
   localparam logic [DUTY_BITS-1:0] MIN_DUTY_RESET   = 10'd250;
   localparam logic [DUTY_BITS-1:0] MAX_DUTY_RESET   = 10'd724;

   // Quadrature step, indexed by {previous pins, current pins}.
   localparam logic signed [1:0] QUAD_STEP [16] = '{
      2'sd0,  2'sd1,  -2'sd1, 2'sd0,
      -2'sd1, 2'sd0,  2'sd0,  2'sd1,
      2'sd1,  2'sd0,  2'sd0,  -2'sd1,
      2'sd0,  -2'sd1, 2'sd1,  2'sd0
   };

   typedef enum logic [1:0] {
      ACT_SAMPLE = 2'd0,
      ACT_DRIVE  = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_STOP   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      HEAD_STOP = 2'd0,
      HEAD_FWD  = 2'd1,
      HEAD_BACK = 2'd2
   } heading_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GAIN_P     = 3'd0,
      CSR_GAIN_I     = 3'd1,
      CSR_GAIN_D     = 3'd2,
      CSR_LEFT_TRIM  = 3'd3,
      CSR_RIGHT_TRIM = 3'd4,
      CSR_MIN_DUTY   = 3'd5,
      CSR_MAX_DUTY   = 3'd6
   } csr_index_type;

   // Per-item fields that ride along the pipeline.
   typedef struct packed {
      action_type           action;
      logic                 go_back;
      logic [DUTY_BITS-1:0] speed;
      heading_type          heading;
      logic                 reversed;
      logic [POS_BITS-1:0]  left_position;
      logic [POS_BITS-1:0]  right_position;
   } item_tag_type;

   typedef struct packed {
      item_tag_type                tag;
      logic signed [ERR_BITS-1:0]  error;
      logic signed [ERR_BITS-1:0]  error_sum;
      logic signed [DIFF_BITS-1:0] error_diff;
   } track_type;

   typedef struct packed {
      item_tag_type                tag;
      logic signed [PROD_BITS-1:0] p_term;
      logic signed [PROD_BITS-1:0] i_term;
      logic signed [PROD_BITS-1:0] d_term;
   } prod_type;

   typedef struct packed {
      item_tag_type               tag;
      logic signed [PID_BITS-1:0] pid;
   } sum_type;

   typedef struct packed {
      logic prod_load;
      logic sum_load;
   } mult_load_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0] left_duty;
      logic [DUTY_BITS-1:0] right_duty;
      logic [1:0]           motion;
      logic                 reversed;
      logic [POS_BITS-1:0]  left_position;
      logic [POS_BITS-1:0]  right_position;
   } rsp_type;

endpackage

>>> rtl/core/qpws_track.sv
module qpws_track import qpws_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  action_type           action,
   input  logic [1:0]           left_pins,
   input  logic [1:0]           right_pins,
   input  logic                 go_back,
   input  logic [DUTY_BITS-1:0] speed,
   output track_type            trk_q
);

   logic [COUNT_BITS-1:0]        left_count_ff, left_count_in;
   logic [COUNT_BITS-1:0]        right_count_ff, right_count_in;
   logic [1:0]                   left_prev_ff, left_prev_in;
   logic [1:0]                   right_prev_ff, right_prev_in;
   logic signed [ERR_BITS-1:0]   error_sum_ff, error_sum_in;
   logic signed [ERR_BITS-1:0]   last_error_ff, last_error_in;
   heading_type                  heading_ff, heading_in, want;
   logic                         reversed;
   logic signed [1:0]            left_step, right_step;
   logic signed [COUNT_BITS-1:0] left_cur_s, right_cur_s, left_next_s, right_next_s;
   logic signed [ERR_BITS-1:0]   error, sum_base, last_base;
   track_type                    trk_ff, trk_in;

   always_comb begin
      left_step   = QUAD_STEP[{left_prev_ff, left_pins}];
      right_step  = QUAD_STEP[{right_prev_ff, right_pins}];
      want        = go_back ? HEAD_BACK : HEAD_FWD;
      reversed    = (action == ACT_DRIVE) && (heading_ff != HEAD_STOP) && (heading_ff != want);
      left_cur_s  = signed'(left_count_ff);
      right_cur_s = signed'(right_count_ff);
      // Error, wrapped to 32 bits, from the signed counts.
      error       = ERR_BITS'(left_cur_s) - ERR_BITS'(right_cur_s);
      // A reversal drops the PID history before this update uses it.
      sum_base    = reversed ? '0 : error_sum_ff;
      last_base   = reversed ? '0 : last_error_ff;

      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      left_prev_in   = left_prev_ff;
      right_prev_in  = right_prev_ff;
      error_sum_in   = error_sum_ff;
      last_error_in  = last_error_ff;
      heading_in     = heading_ff;

      unique case (action)
         ACT_SAMPLE: begin
            left_count_in  = left_count_ff + COUNT_BITS'(left_step);
            right_count_in = right_count_ff + COUNT_BITS'(right_step);
            left_prev_in   = left_pins;
            right_prev_in  = right_pins;
         end
         ACT_DRIVE: begin
            error_sum_in  = sum_base + error;
            last_error_in = error;
            heading_in    = want;
         end
         ACT_CLEAR: begin
            left_count_in  = '0;
            right_count_in = '0;
            left_prev_in   = '0;
            right_prev_in  = '0;
         end
         ACT_STOP: begin
            heading_in = HEAD_STOP;
         end
         default: ;
      endcase

      left_next_s  = signed'(left_count_in);
      right_next_s = signed'(right_count_in);

      trk_in.tag.action         = action;
      trk_in.tag.go_back        = go_back;
      trk_in.tag.speed          = speed;
      trk_in.tag.heading        = heading_in;
      trk_in.tag.reversed       = reversed;
      trk_in.tag.left_position  = POS_BITS'(left_next_s);
      trk_in.tag.right_position = POS_BITS'(right_next_s);
      trk_in.error              = error;
      trk_in.error_sum          = sum_base + error;
      trk_in.error_diff         = DIFF_BITS'(error) - DIFF_BITS'(last_base);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_count_ff  <= '0;
         right_count_ff <= '0;
         left_prev_ff   <= '0;
         right_prev_ff  <= '0;
         error_sum_ff   <= '0;
         last_error_ff  <= '0;
         heading_ff     <= HEAD_STOP;
      end else if (load) begin
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
         left_prev_ff   <= left_prev_in;
         right_prev_ff  <= right_prev_in;
         error_sum_ff   <= error_sum_in;
         last_error_ff  <= last_error_in;
         heading_ff     <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         trk_ff <= trk_in;
      end
   end

   assign trk_q = trk_ff;

endmodule

>>> rtl/core/qpws_mult.sv
module qpws_mult import qpws_pkg::*; (
   input  logic                 clock,
   input  mult_load_type        load,
   input  track_type            trk_q,
   input  logic [GAIN_BITS-1:0] gain_p,
   input  logic [GAIN_BITS-1:0] gain_i,
   input  logic [GAIN_BITS-1:0] gain_d,
   output sum_type              sum_q
);

   logic signed [GAIN_BITS:0] gp_s, gi_s, gd_s;
   prod_type                  prod_ff, prod_in;
   sum_type                   sum_ff, sum_in;

   always_comb begin
      gp_s = signed'({1'b0, gain_p});
      gi_s = signed'({1'b0, gain_i});
      gd_s = signed'({1'b0, gain_d});

      prod_in.tag    = trk_q.tag;
      prod_in.p_term = gp_s * trk_q.error;
      prod_in.i_term = gi_s * trk_q.error_sum;
      prod_in.d_term = gd_s * trk_q.error_diff;

      sum_in.tag = prod_ff.tag;
      sum_in.pid = PID_BITS'(prod_ff.p_term) + PID_BITS'(prod_ff.i_term)
                 + PID_BITS'(prod_ff.d_term);
   end

   always_ff @(posedge clock) begin
      if (load.prod_load) begin
         prod_ff <= prod_in;
      end
      if (load.sum_load) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_q = sum_ff;

endmodule

>>> rtl/core/qpws_drive.sv
module qpws_drive import qpws_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  sum_type              sum_q,
   input  logic [DUTY_BITS-1:0] left_trim,
   input  logic [DUTY_BITS-1:0] right_trim,
   input  logic [DUTY_BITS-1:0] min_duty,
   input  logic [DUTY_BITS-1:0] max_duty,
   output rsp_type              rsp_q
);

   logic signed [PID_BITS-1:0]       pid_biased;
   logic signed [CORR_FULL_BITS-1:0] corr_full;
   logic signed [CORR_BITS-1:0]      corr_sat;
   logic signed [CALC_BITS-1:0]      corr_ext, corr_dir, speed_s, ltrim_s, rtrim_s;
   logic signed [CALC_BITS-1:0]      left_raw, right_raw;
   logic [DUTY_BITS-1:0]             duty_left_ff, duty_left_in;
   logic [DUTY_BITS-1:0]             duty_right_ff, duty_right_in;
   rsp_type                          rsp_ff;

   // Lower bound first, then upper bound: an inverted pair yields the upper one.
   function automatic logic [DUTY_BITS-1:0] clamp_duty(
      input logic signed [CALC_BITS-1:0] v,
      input logic [DUTY_BITS-1:0]        lo,
      input logic [DUTY_BITS-1:0]        hi
   );
      logic signed [CALC_BITS-1:0] lo_s, hi_s, t;
      lo_s = signed'(CALC_BITS'(lo));
      hi_s = signed'(CALC_BITS'(hi));
      t    = (v < lo_s) ? lo_s : v;
      t    = (t > hi_s) ? hi_s : t;
      return t[DUTY_BITS-1:0];
   endfunction

   always_comb begin
      // Bias negative sums so the shift truncates toward zero.
      pid_biased = sum_q.pid + signed'({{(PID_BITS-GAIN_FRAC_BITS){1'b0}},
                                        {GAIN_FRAC_BITS{sum_q.pid[PID_BITS-1]}}});
      corr_full  = signed'(pid_biased[PID_BITS-1:GAIN_FRAC_BITS]);
      if (corr_full > CORR_FULL_BITS'(CORR_HI)) begin
         corr_sat = CORR_HI;
      end else if (corr_full < CORR_FULL_BITS'(CORR_LO)) begin
         corr_sat = CORR_LO;
      end else begin
         corr_sat = signed'(corr_full[CORR_BITS-1:0]);
      end
      corr_ext  = CALC_BITS'(corr_sat);
      corr_dir  = sum_q.tag.go_back ? -corr_ext : corr_ext;
      speed_s   = signed'(CALC_BITS'(sum_q.tag.speed));
      ltrim_s   = signed'(CALC_BITS'(left_trim));
      rtrim_s   = signed'(CALC_BITS'(right_trim));
      left_raw  = speed_s - corr_dir - ltrim_s;
      right_raw = speed_s + corr_dir - rtrim_s;

      duty_left_in  = duty_left_ff;
      duty_right_in = duty_right_ff;
      case (sum_q.tag.action)
         ACT_DRIVE: begin
            duty_left_in  = clamp_duty(left_raw, min_duty, max_duty);
            duty_right_in = clamp_duty(right_raw, min_duty, max_duty);
         end
         ACT_STOP: begin
            duty_left_in  = '0;
            duty_right_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_left_ff  <= '0;
         duty_right_ff <= '0;
      end else if (load) begin
         duty_left_ff  <= duty_left_in;
         duty_right_ff <= duty_right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff.motion         <= sum_q.tag.heading;
         rsp_ff.reversed       <= sum_q.tag.reversed;
         rsp_ff.left_position  <= sum_q.tag.left_position;
         rsp_ff.right_position <= sum_q.tag.right_position;
      end
   end

   always_comb begin
      rsp_q.left_duty      = duty_left_ff;
      rsp_q.right_duty     = duty_right_ff;
      rsp_q.motion         = rsp_ff.motion;
      rsp_q.reversed       = rsp_ff.reversed;
      rsp_q.left_position  = rsp_ff.left_position;
      rsp_q.right_position = rsp_ff.right_position;
   end

endmodule

>>> rtl/core/quadrature_pid_wheel_sync.sv
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: action; tdata: pins, go_back, speed
// rsp      out  rsp_tvalid/rsp_tready  tdata: duties, motion, reversed, positions
// csr      in   csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// One transaction in and one out per clock while rsp is not stalled; each result passes
// through the track, product, sum and output register stages after acceptance.
// Encoder and PID state update at the accepting edge, so items may follow back to back.
// Reset is synchronous: config, valid bits, counts, PID, heading and duties go to defaults.
// A stalled rsp holds only the stages that are full; up to four transactions in flight.
module quadrature_pid_wheel_sync import qpws_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // left_pins, right_pins, go_back, speed
   input  logic [1:0]                req_tuser,   // action
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // left_duty, right_duty, motion, reversed, left_position, right_position
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [GAIN_BITS-1:0]      csr_data
);

   // Configuration registers.
   logic [GAIN_BITS-1:0] gain_p_ff, gain_p_in, gain_i_ff, gain_i_in, gain_d_ff, gain_d_in;
   logic [DUTY_BITS-1:0] left_trim_ff, left_trim_in, right_trim_ff, right_trim_in;
   logic [DUTY_BITS-1:0] min_duty_ff, min_duty_in, max_duty_ff, max_duty_in;

   // Stage valid bits and their ready terms.
   logic          trk_valid_ff, trk_valid_in, prod_valid_ff, prod_valid_in;
   logic          sum_valid_ff, sum_valid_in, rsp_valid_ff, rsp_valid_in;
   logic          trk_ready, prod_ready, sum_ready, out_ready;
   logic          trk_load, out_load;
   mult_load_type mult_load;

   track_type     trk_q;
   sum_type       sum_q;
   rsp_type       rsp_q;

   assign csr_ready = 1'b1;

   // Register writes; indexes past the list are dropped.
   always_comb begin
      gain_p_in     = gain_p_ff;
      gain_i_in     = gain_i_ff;
      gain_d_in     = gain_d_ff;
      left_trim_in  = left_trim_ff;
      right_trim_in = right_trim_ff;
      min_duty_in   = min_duty_ff;
      max_duty_in   = max_duty_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:     gain_p_in     = csr_data;
            CSR_GAIN_I:     gain_i_in     = csr_data;
            CSR_GAIN_D:     gain_d_in     = csr_data;
            CSR_LEFT_TRIM:  left_trim_in  = csr_data[DUTY_BITS-1:0];
            CSR_RIGHT_TRIM: right_trim_in = csr_data[DUTY_BITS-1:0];
            CSR_MIN_DUTY:   min_duty_in   = csr_data[DUTY_BITS-1:0];
            CSR_MAX_DUTY:   max_duty_in   = csr_data[DUTY_BITS-1:0];
            default: ;
         endcase
      end
   end

   // A stage takes new data when it is empty or its contents move on this cycle.
   always_comb begin
      out_ready  = !rsp_valid_ff || rsp_tready;
      sum_ready  = !sum_valid_ff || out_ready;
      prod_ready = !prod_valid_ff || sum_ready;
      trk_ready  = !trk_valid_ff || prod_ready;

      trk_load           = req_tvalid && trk_ready;
      mult_load.prod_load = trk_valid_ff && prod_ready;
      mult_load.sum_load  = prod_valid_ff && sum_ready;
      out_load           = sum_valid_ff && out_ready;

      trk_valid_in  = trk_ready  ? req_tvalid    : trk_valid_ff;
      prod_valid_in = prod_ready ? trk_valid_ff  : prod_valid_ff;
      sum_valid_in  = sum_ready  ? prod_valid_ff : sum_valid_ff;
      rsp_valid_in  = out_ready  ? sum_valid_ff  : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= GAIN_P_RESET;
         gain_i_ff     <= GAIN_I_RESET;
         gain_d_ff     <= GAIN_D_RESET;
         left_trim_ff  <= LEFT_TRIM_RESET;
         right_trim_ff <= RIGHT_TRIM_RESET;
         min_duty_ff   <= MIN_DUTY_RESET;
         max_duty_ff   <= MAX_DUTY_RESET;
         trk_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         gain_p_ff     <= gain_p_in;
         gain_i_ff     <= gain_i_in;
         gain_d_ff     <= gain_d_in;
         left_trim_ff  <= left_trim_in;
         right_trim_ff <= right_trim_in;
         min_duty_ff   <= min_duty_in;
         max_duty_ff   <= max_duty_in;
         trk_valid_ff  <= trk_valid_in;
         prod_valid_ff <= prod_valid_in;
         sum_valid_ff  <= sum_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_tready = trk_ready;
   assign rsp_tvalid = rsp_valid_ff;

   // Counts, pin history, PID history and heading advance here.
   qpws_track u_track (
      .clock      (clock),
      .reset      (reset),
      .load       (trk_load),
      .action     (action_type'(req_tuser)),
      .left_pins  (req_tdata[1:0]),
      .right_pins (req_tdata[3:2]),
      .go_back    (req_tdata[4]),
      .speed      (req_tdata[5 +: DUTY_BITS]),
      .trk_q      (trk_q)
   );

   // Gain products, then their sum.
   qpws_mult u_mult (
      .clock  (clock),
      .load   (mult_load),
      .trk_q  (trk_q),
      .gain_p (gain_p_ff),
      .gain_i (gain_i_ff),
      .gain_d (gain_d_ff),
      .sum_q  (sum_q)
   );

   // Correction, trim and clamp into the duty registers; holds the result.
   qpws_drive u_drive (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .sum_q      (sum_q),
      .left_trim  (left_trim_ff),
      .right_trim (right_trim_ff),
      .min_duty   (min_duty_ff),
      .max_duty   (max_duty_ff),
      .rsp_q      (rsp_q)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS-RSP_FIELD_BITS){1'b0}},
                       rsp_q.right_position, rsp_q.left_position, rsp_q.reversed,
                       rsp_q.motion, rsp_q.right_duty, rsp_q.left_duty};

`include "quadrature_pid_wheel_sync_assert.svh"

   // A stopped heading always reports idle motors.
   `QPWS_ASSERT_NOW(a_stop_zero_duty, rsp_valid_ff && (rsp_q.motion == HEAD_STOP), (rsp_q.left_duty == '0) && (rsp_q.right_duty == '0))

   // A reversal only comes with a new direction.
   `QPWS_ASSERT_NOW(a_reverse_moving, rsp_valid_ff && rsp_q.reversed, (rsp_q.motion == HEAD_FWD) || (rsp_q.motion == HEAD_BACK))

   // A blocked track stage keeps its item.
   `QPWS_ASSERT_NEXT(a_track_hold, trk_valid_ff && !prod_ready, trk_valid_ff && $stable(trk_q))

   // Stop heads the item to a standstill as it leaves the track stage.
   `QPWS_ASSERT_NEXT(a_stop_heading, trk_load && (req_tuser == ACT_STOP), trk_q.tag.heading == HEAD_STOP)

endmodule
